### hw/rtl/ccrb_pkg.sv
// ----------------------------------------------------------------------------
// ccrb_pkg
// Shared types, codes and constants for the station transmit controller with
// truncated binary exponential backoff.
// ----------------------------------------------------------------------------
package ccrb_pkg;

  // default limits
  localparam int MAX_ATTEMPTS_DEF = 16;
  localparam int BACKOFF_CAP_DEF  = 10;

  // field widths
  localparam int OP_W      = 2;
  localparam int FRAME_W   = 16;
  localparam int STATION_W = 8;
  localparam int RAND_W    = 10;
  localparam int KIND_W    = 2;
  localparam int PART_W    = 2;
  localparam int ATTEMPT_W = 5;
  localparam int TICKS_W   = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;

  // configuration reset values
  localparam logic [STATION_W-1:0] STATION_RST = 8'd1;
  localparam logic [TICKS_W-1:0]   SLOT_TICKS_RST = 20'd100000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STATION    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS = 1'd1;

  // input operation codes
  localparam logic [OP_W-1:0] OP_NEW_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLY     = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACKOFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd3;

  // frame parts
  localparam logic [PART_W-1:0] PART_ONE = 2'd1;
  localparam logic [PART_W-1:0] PART_TWO = 2'd2;

  // controller phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT1   = 2'd1;
  localparam logic [1:0] PH_WAIT2   = 2'd2;
  localparam logic [1:0] PH_BACKOFF = 2'd3;

  // result queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [FRAME_W-1:0]   frame_tag;
    logic [STATION_W-1:0] dest_station;
    logic                 reply_ok;
    logic [RAND_W-1:0]    random_bits;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [FRAME_W-1:0]   frame_tag;
    logic [PART_W-1:0]    part;
    logic [STATION_W-1:0] source_station;
    logic [STATION_W-1:0] dest_station;
    logic [ATTEMPT_W-1:0] attempt;
    logic [RAND_W-1:0]    wait_slots;
    logic                 last;
  } result_t;

  // results pushed by one accepted beat
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

### hw/rtl/ccrb_ifs.sv
// ----------------------------------------------------------------------------
// ccrb channel interfaces
// Valid/ready channels for command beats into and result beats out of the
// transmit controller.
// ----------------------------------------------------------------------------
interface ccrb_in_if;
  logic                             valid;
  logic                             ready;
  logic [ccrb_pkg::OP_W-1:0]        op;
  logic [ccrb_pkg::FRAME_W-1:0]     frame_tag;
  logic [ccrb_pkg::STATION_W-1:0]   dest_station;
  logic                             reply_ok;
  logic [ccrb_pkg::RAND_W-1:0]      random_bits;

  modport source (output valid, op, frame_tag, dest_station, reply_ok, random_bits,
                  input ready);
  modport sink   (input valid, op, frame_tag, dest_station, reply_ok, random_bits,
                  output ready);
endinterface

interface ccrb_out_if;
  logic                             valid;
  logic                             ready;
  logic [ccrb_pkg::KIND_W-1:0]      kind;
  logic [ccrb_pkg::FRAME_W-1:0]     out_frame_tag;
  logic [ccrb_pkg::PART_W-1:0]      part;
  logic [ccrb_pkg::STATION_W-1:0]   source_station;
  logic [ccrb_pkg::STATION_W-1:0]   out_dest_station;
  logic [ccrb_pkg::ATTEMPT_W-1:0]   attempt;
  logic [ccrb_pkg::RAND_W-1:0]      wait_slots;
  logic                             last;

  modport source (output valid, kind, out_frame_tag, part, source_station,
                  out_dest_station, attempt, wait_slots, last,
                  input ready);
  modport sink   (input valid, kind, out_frame_tag, part, source_station,
                  out_dest_station, attempt, wait_slots, last,
                  output ready);
endinterface

### hw/rtl/ccrb_core.sv
// ----------------------------------------------------------------------------
// ccrb_core
// Frame state, attempt counter and backoff counters. One accepted beat makes
// one state update and up to two result beats.
// ----------------------------------------------------------------------------
module ccrb_core #(
  parameter int MAX_ATTEMPTS = ccrb_pkg::MAX_ATTEMPTS_DEF,
  parameter int BACKOFF_CAP  = ccrb_pkg::BACKOFF_CAP_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  ccrb_pkg::in_beat_t                beat,
  input  logic                              cfg_we,
  input  logic [ccrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccrb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ccrb_pkg::push_t                   push
);

  localparam logic [ccrb_pkg::ATTEMPT_W-1:0] MAX_ATT = ccrb_pkg::ATTEMPT_W'(MAX_ATTEMPTS);
  localparam logic [ccrb_pkg::ATTEMPT_W-1:0] CAP     = ccrb_pkg::ATTEMPT_W'(BACKOFF_CAP);

  // configuration registers
  logic [ccrb_pkg::STATION_W-1:0] station_number;
  logic [ccrb_pkg::TICKS_W-1:0]   slot_ticks;

  // controller state
  logic [1:0]                     phase, phase_next;
  logic [ccrb_pkg::ATTEMPT_W-1:0] attempt_count, attempt_count_next;
  logic [ccrb_pkg::FRAME_W-1:0]   held_frame_tag, held_frame_tag_next;
  logic [ccrb_pkg::STATION_W-1:0] held_dest, held_dest_next;
  logic [ccrb_pkg::RAND_W-1:0]    slots_left, slots_left_next;
  logic [ccrb_pkg::TICKS_W-1:0]   ticks_left, ticks_left_next;

  logic [ccrb_pkg::TICKS_W-1:0]   slot_len;
  logic [ccrb_pkg::ATTEMPT_W-1:0] mask_bits;
  logic [ccrb_pkg::RAND_W-1:0]    mask;
  logic [ccrb_pkg::RAND_W-1:0]    wait_val;
  logic [ccrb_pkg::PART_W-1:0]    cur_part;
  logic [ccrb_pkg::TICKS_W-1:0]   ticks_dec;
  logic [ccrb_pkg::RAND_W-1:0]    slots_dec;

  // a zero slot length counts as one tick
  assign slot_len = (slot_ticks == '0) ? ccrb_pkg::TICKS_W'(1) : slot_ticks;

  // backoff window: min(attempt, cap) low bits of the random value
  assign mask_bits = (attempt_count > CAP) ? CAP : attempt_count;
  always_comb begin
    for (int i = 0; i < ccrb_pkg::RAND_W; i++) begin
      mask[i] = (ccrb_pkg::ATTEMPT_W'(i) < mask_bits);
    end
  end
  assign wait_val = beat.random_bits & mask;
  assign cur_part = (phase == ccrb_pkg::PH_WAIT1) ? ccrb_pkg::PART_ONE : ccrb_pkg::PART_TWO;

  assign ticks_dec = (ticks_left != '0) ? ticks_left - 1'b1 : ticks_left;
  assign slots_dec = (slots_left != '0) ? slots_left - 1'b1 : slots_left;

  // next state and results for the beat at the input
  always_comb begin
    phase_next          = phase;
    attempt_count_next  = attempt_count;
    held_frame_tag_next = held_frame_tag;
    held_dest_next      = held_dest;
    slots_left_next     = slots_left;
    ticks_left_next     = ticks_left;

    push.push0 = 1'b0;
    push.push1 = 1'b0;
    push.res0.kind           = ccrb_pkg::KIND_SEND;
    push.res0.frame_tag      = held_frame_tag;
    push.res0.part           = ccrb_pkg::PART_ONE;
    push.res0.source_station = station_number;
    push.res0.dest_station   = held_dest;
    push.res0.attempt        = attempt_count;
    push.res0.wait_slots     = '0;
    push.res0.last           = 1'b1;
    // second beat only follows a zero-length backoff: part 1 resend
    push.res1.kind           = ccrb_pkg::KIND_SEND;
    push.res1.frame_tag      = held_frame_tag;
    push.res1.part           = ccrb_pkg::PART_ONE;
    push.res1.source_station = station_number;
    push.res1.dest_station   = held_dest;
    push.res1.attempt        = attempt_count + 1'b1;
    push.res1.wait_slots     = '0;
    push.res1.last           = 1'b1;

    case (beat.op)
      ccrb_pkg::OP_NEW_FRAME: begin
        if (phase == ccrb_pkg::PH_IDLE) begin
          held_frame_tag_next = beat.frame_tag;
          held_dest_next      = beat.dest_station;
          attempt_count_next  = ccrb_pkg::ATTEMPT_W'(1);
          phase_next          = ccrb_pkg::PH_WAIT1;
          push.push0          = 1'b1;
          push.res0.frame_tag    = beat.frame_tag;
          push.res0.dest_station = beat.dest_station;
          push.res0.attempt      = ccrb_pkg::ATTEMPT_W'(1);
        end
      end
      ccrb_pkg::OP_REPLY: begin
        if (phase == ccrb_pkg::PH_WAIT1 || phase == ccrb_pkg::PH_WAIT2) begin
          push.push0 = 1'b1;
          if (beat.reply_ok) begin
            if (phase == ccrb_pkg::PH_WAIT1) begin
              phase_next     = ccrb_pkg::PH_WAIT2;
              push.res0.part = ccrb_pkg::PART_TWO;
            end else begin
              phase_next     = ccrb_pkg::PH_IDLE;
              push.res0.kind = ccrb_pkg::KIND_DONE;
              push.res0.part = ccrb_pkg::PART_TWO;
            end
          end else if (attempt_count == MAX_ATT) begin
            phase_next     = ccrb_pkg::PH_IDLE;
            push.res0.kind = ccrb_pkg::KIND_FAIL;
            push.res0.part = cur_part;
          end else begin
            push.res0.kind       = ccrb_pkg::KIND_BACKOFF;
            push.res0.part       = cur_part;
            push.res0.wait_slots = wait_val;
            if (wait_val == '0) begin
              push.res0.last     = 1'b0;
              push.push1         = 1'b1;
              attempt_count_next = attempt_count + 1'b1;
              phase_next         = ccrb_pkg::PH_WAIT1;
            end else begin
              phase_next      = ccrb_pkg::PH_BACKOFF;
              slots_left_next = wait_val;
              ticks_left_next = slot_len;
            end
          end
        end
      end
      ccrb_pkg::OP_TICK: begin
        if (phase == ccrb_pkg::PH_BACKOFF) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            slots_left_next = slots_dec;
            if (slots_dec == '0) begin
              attempt_count_next = attempt_count + 1'b1;
              phase_next         = ccrb_pkg::PH_WAIT1;
              push.push0         = 1'b1;
              push.res0.attempt  = attempt_count + 1'b1;
            end else begin
              ticks_left_next = slot_len;
            end
          end
        end
      end
      default: begin
        // unused op code: no effect
      end
    endcase

    if (!accept) begin
      push.push0 = 1'b0;
      push.push1 = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      station_number <= ccrb_pkg::STATION_RST;
      slot_ticks     <= ccrb_pkg::SLOT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccrb_pkg::REG_STATION:    station_number <= cfg_data[ccrb_pkg::STATION_W-1:0];
        ccrb_pkg::REG_SLOT_TICKS: slot_ticks     <= cfg_data[ccrb_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ccrb_pkg::PH_IDLE;
      attempt_count  <= '0;
      held_frame_tag <= '0;
      held_dest      <= '0;
      slots_left     <= '0;
      ticks_left     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      attempt_count  <= attempt_count_next;
      held_frame_tag <= held_frame_tag_next;
      held_dest      <= held_dest_next;
      slots_left     <= slots_left_next;
      ticks_left     <= ticks_left_next;
    end
  end

endmodule

### hw/rtl/ccrb_result_fifo.sv
// ----------------------------------------------------------------------------
// ccrb_result_fifo
// Small result queue: takes up to two result beats per cycle, hands out one.
// Reports room while at least two entries are free.
// ----------------------------------------------------------------------------
module ccrb_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  ccrb_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              head_valid,
  output ccrb_pkg::result_t head
);

  localparam int DEPTH = ccrb_pkg::FIFO_DEPTH;
  localparam int PTR_W = ccrb_pkg::FIFO_PTR_W;
  localparam int CNT_W = ccrb_pkg::FIFO_CNT_W;

  ccrb_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count, count_next;
  logic              do_pop;

  assign do_pop     = pop && (count != '0);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign room       = (count <= CNT_W'(DEPTH - 2));
  assign count_next = count + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(do_pop);

  // storage
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr + 1'b1] <= push.res1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.push0) + PTR_W'(push.push1);
      rd_ptr <= rd_ptr + PTR_W'(do_pop);
      count  <= count_next;
    end
  end

endmodule

### hw/rtl/csma_cd_retry_backoff.sv
// ----------------------------------------------------------------------------
// csma_cd_retry_backoff
// Station transmit controller: two-part frames, bus replies, truncated binary
// exponential backoff counted in ticks, failure after the last attempt.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     beat contents
//  in_ch     in   valid/ready   op, frame_tag, dest_station, reply_ok, random_bits
//  out_ch    out  valid/ready   kind, out_frame_tag, part, source_station,
//                               out_dest_station, attempt, wait_slots, last
//  cfg       in   cfg_we        cfg_index, cfg_data (no read-back)
//
//  Each command beat is handled in the cycle it is accepted; its results go
//  through the registered result queue to out_ch, and a zero backoff adds a second
//  beat right behind the first, one result beat per cycle at most.
//  One command beat per cycle is sustained while results drain; the limit is
//  the four-entry result queue, which takes a command while two entries are free.
//  Synchronous reset restores configuration and idles the controller; no sweep.
//  A stalled out_ch fills the queue and then holds in_ch ready low.
// ----------------------------------------------------------------------------
module csma_cd_retry_backoff #(
  parameter int MAX_ATTEMPTS = ccrb_pkg::MAX_ATTEMPTS_DEF,
  parameter int BACKOFF_CAP  = ccrb_pkg::BACKOFF_CAP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  ccrb_in_if.sink                          in_ch,
  ccrb_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ccrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccrb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ccrb_pkg::in_beat_t beat;
  ccrb_pkg::push_t    push;
  ccrb_pkg::result_t  head;
  logic               room;
  logic               head_valid;
  logic               accept;

  // command beat
  assign beat.op           = in_ch.op;
  assign beat.frame_tag    = in_ch.frame_tag;
  assign beat.dest_station = in_ch.dest_station;
  assign beat.reply_ok     = in_ch.reply_ok;
  assign beat.random_bits  = in_ch.random_bits;
  assign in_ch.ready       = room;
  assign accept            = in_ch.valid && room;

  ccrb_core #(
    .MAX_ATTEMPTS (MAX_ATTEMPTS),
    .BACKOFF_CAP  (BACKOFF_CAP)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .beat      (beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  ccrb_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (out_ch.ready),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // result beat
  assign out_ch.valid            = head_valid;
  assign out_ch.kind             = head.kind;
  assign out_ch.out_frame_tag    = head.frame_tag;
  assign out_ch.part             = head.part;
  assign out_ch.source_station   = head.source_station;
  assign out_ch.out_dest_station = head.dest_station;
  assign out_ch.attempt          = head.attempt;
  assign out_ch.wait_slots       = head.wait_slots;
  assign out_ch.last             = head.last;

endmodule

### hw/rtl/ccrb_checker.sv
// ----------------------------------------------------------------------------
// ccrb_checker
// Port-level checks on the transmit controller, bound to the top level.
// ----------------------------------------------------------------------------
module ccrb_checker #(
  parameter int MAX_ATTEMPTS = ccrb_pkg::MAX_ATTEMPTS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ccrb_pkg::KIND_W-1:0]      kind,
  input logic [ccrb_pkg::PART_W-1:0]      part,
  input logic [ccrb_pkg::ATTEMPT_W-1:0]   attempt,
  input logic [ccrb_pkg::RAND_W-1:0]      wait_slots,
  input logic                             last
);

  // nothing comes out right after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a failure only comes on the final attempt
  a_fail_attempt: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ccrb_pkg::KIND_FAIL |->
      attempt == ccrb_pkg::ATTEMPT_W'(MAX_ATTEMPTS) && last)
    else $error("failure before the last attempt");

  // only a zero backoff is followed by a second beat, the part 1 resend
  a_zero_backoff: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |->
      kind == ccrb_pkg::KIND_BACKOFF && wait_slots == '0 ##1
      out_valid && kind == ccrb_pkg::KIND_SEND && part == ccrb_pkg::PART_ONE)
    else $error("unexpected follow-on beat");

  // wait length only carried by backoff beats
  a_wait_only_backoff: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != ccrb_pkg::KIND_BACKOFF |-> wait_slots == '0)
    else $error("wait length on a non-backoff beat");

endmodule

bind csma_cd_retry_backoff ccrb_checker #(
  .MAX_ATTEMPTS (MAX_ATTEMPTS)
) u_ccrb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .part       (out_ch.part),
  .attempt    (out_ch.attempt),
  .wait_slots (out_ch.wait_slots),
  .last       (out_ch.last)
);
